@@ src/ipsp_pkg.sv @@
// ipsp_pkg: shared types and constants of the ips patch stream parser
// no dependencies; imported by ips_patch_stream_parser_unit
package ipsp_pkg;

   // result event codes
   localparam logic [2:0] EV_LIT    = 3'd0;
   localparam logic [2:0] EV_RUN    = 3'd1;
   localparam logic [2:0] EV_BADHDR = 3'd2;
   localparam logic [2:0] EV_FIN    = 3'd3;
   localparam logic [2:0] EV_TRUNC  = 3'd4;

   // record address that marks the end of the patch ("EOF")
   localparam logic [23:0] EOF_MARK = 24'h454F46;

   // largest value the write pointer may reach (one past the 24-bit space)
   localparam logic [24:0] ADDR_SPACE = 25'h1000000;

   // header bytes "PATCH"
   localparam logic [7:0] MAGIC [5] = '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48};

   // one result transaction
   typedef struct packed {
      logic [2:0]  event_res;
      logic [23:0] write_addr;
      logic [7:0]  write_value;
      logic [15:0] run_length;
      logic        clipped;
      logic [24:0] final_size;
      logic        last_result;
   } result_type;

endpackage

@@ src/ips_patch_stream_parser_unit.sv @@
// ips_patch_stream_parser_unit: byte-wide ips patch parser, top level
// depends on ipsp_pkg for the result type, event codes and header bytes
//
// The block takes one patch byte per cycle on the req_ stream and emits write
// commands on the rsp_ stream: a one-byte write for each literal byte, a single
// run write for a nonzero-count fill record, a finish or truncation event that
// carries the patched image size, and a bad-header event. Each byte is parsed
// by one stage of logic between the parser state registers and a four-entry
// result queue, so a byte is accepted every cycle while the queue has two free
// entries; only a stream's last byte can add two results. The rsp_ side may
// stall freely; req_tready drops once three or more results are queued. The
// user must write base_size through csr_ while idle; the block does not check.
module ips_patch_stream_parser_unit #(
   parameter int MEM_BYTES = 16777216
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [24:0] csr_write_data,    // base_size
   // patch byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,         // patch_byte
   input  logic        req_tlast,         // last_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,         // write_addr[23:0], write_value[31:24],
                                          // run_length[47:32], clipped[48],
                                          // final_size[73:49], zero fill [79:74]
   output logic [2:0]  rsp_tuser,         // event_res
   output logic        rsp_tlast          // last_result
);
   import ipsp_pkg::*;

   localparam logic [24:0] MEM_LIMIT = 25'(MEM_BYTES);

   // parser phases
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_ADDR   = 3'd1;
   localparam logic [2:0] PH_LEN    = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_RUNLEN = 3'd4;
   localparam logic [2:0] PH_RUNVAL = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;

   // parser state
   logic [24:0] base_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  index_ff, index_in;
   logic [23:0] raddr_ff, raddr_in;
   logic [15:0] rlen_ff, rlen_in;
   logic [24:0] wptr_ff, wptr_in;
   logic [24:0] hend_ff, hend_in;

   // result queue
   result_type  queue_ff [4];
   logic [1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [2:0]  count_ff, count_in;

   logic        req_accept, rsp_accept;
   result_type  res0, res1;
   logic [1:0]  res_count;
   logic [2:0]  index_inc;
   logic [23:0] addr_shift;
   logic [15:0] len_shift;
   logic [24:0] base_clamp, run_end, wptr_inc;
   logic        start;

   // patched image size: the larger of the clamped base size and the highest end
   function automatic logic [24:0] image_size(input logic [24:0] base,
                                              input logic [24:0] hend);
      return (base > hend) ? base : hend;
   endfunction

   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff <= 3'd2);

   assign index_inc  = index_ff + 3'd1;
   assign addr_shift = {raddr_ff[15:0], req_tdata};
   assign len_shift  = {rlen_ff[7:0], req_tdata};
   assign base_clamp = (base_ff > MEM_LIMIT) ? MEM_LIMIT : base_ff;
   assign run_end    = {1'b0, raddr_ff} + {9'd0, rlen_ff};
   assign wptr_inc   = wptr_ff + 25'd1;

   // per-byte parse: next state and up to two results
   always_comb begin
      phase_in  = phase_ff;
      index_in  = index_ff;
      raddr_in  = raddr_ff;
      rlen_in   = rlen_ff;
      wptr_in   = wptr_ff;
      hend_in   = hend_ff;
      res0      = '0;
      res1      = '0;
      res_count = 2'd0;
      start     = 1'b0;
      unique case (phase_ff) inside
         PH_HEADER: begin
            if (req_tdata != MAGIC[index_ff] || req_tlast) begin
               res0.event_res   = EV_BADHDR;
               res0.last_result = 1'b1;
               res_count        = 2'd1;
               if (req_tlast) start = 1'b1;
               else phase_in = PH_DONE;
            end else if (index_inc >= 3'd5) begin
               phase_in = PH_ADDR;
               index_in = 3'd0;
               raddr_in = '0;
            end else begin
               index_in = index_inc;
            end
         end
         PH_ADDR: begin
            raddr_in = addr_shift;
            index_in = index_inc;
            if (index_inc < 3'd3) begin
               if (req_tlast) begin
                  res0.event_res = EV_TRUNC;
                  res_count      = 2'd1;
                  start          = 1'b1;
               end
            end else begin
               index_in = 3'd0;
               if (addr_shift == EOF_MARK) begin
                  res0.event_res = EV_FIN;
                  res_count      = 2'd1;
                  if (req_tlast) start = 1'b1;
                  else phase_in = PH_DONE;
               end else if (req_tlast) begin
                  res0.event_res = EV_TRUNC;
                  res_count      = 2'd1;
                  start          = 1'b1;
               end else begin
                  phase_in = PH_LEN;
                  rlen_in  = '0;
               end
            end
            res0.final_size  = image_size(base_clamp, hend_in);
            res0.last_result = 1'b1;
         end
         PH_LEN, PH_RUNLEN: begin
            rlen_in  = len_shift;
            index_in = index_inc;
            if (index_inc >= 3'd2) begin
               index_in = 3'd0;
               if (phase_ff == PH_RUNLEN) begin
                  phase_in = PH_RUNVAL;
               end else if (len_shift == 16'd0) begin
                  phase_in = PH_RUNLEN;
               end else begin
                  phase_in = PH_DATA;
                  wptr_in  = {1'b0, raddr_ff};
               end
            end
            if (req_tlast) begin
               res0.event_res   = EV_TRUNC;
               res0.final_size  = image_size(base_clamp, hend_in);
               res0.last_result = 1'b1;
               res_count        = 2'd1;
               start            = 1'b1;
            end
         end
         PH_DATA: begin
            // one literal byte write
            res0.event_res   = EV_LIT;
            res0.write_addr  = wptr_ff[23:0];
            res0.write_value = req_tdata;
            res_count        = 2'd1;
            if (wptr_ff < MEM_LIMIT) begin
               res0.run_length = 16'd1;
               if (wptr_inc > hend_ff) hend_in = wptr_inc;
            end else begin
               res0.clipped = 1'b1;
            end
            if (wptr_ff < ADDR_SPACE) wptr_in = wptr_inc;
            if (rlen_ff != 16'd0) rlen_in = rlen_ff - 16'd1;
            if (rlen_in == 16'd0) begin
               phase_in = PH_ADDR;
               index_in = 3'd0;
               raddr_in = '0;
               if (req_tlast) begin
                  res1.event_res = EV_FIN;
                  res_count      = 2'd2;
                  start          = 1'b1;
               end
            end else if (req_tlast) begin
               res1.event_res = EV_TRUNC;
               res_count      = 2'd2;
               start          = 1'b1;
            end
            res1.final_size  = image_size(base_clamp, hend_in);
            res1.last_result = 1'b1;
         end
         PH_RUNVAL: begin
            // fill record, clipped at the end of memory; a zero-count run leaves the end alone
            res0.event_res   = EV_RUN;
            res0.write_addr  = raddr_ff;
            res0.write_value = req_tdata;
            if ({1'b0, raddr_ff} >= MEM_LIMIT) begin
               res0.clipped = 1'b1;
            end else if (run_end > MEM_LIMIT) begin
               res0.run_length = 16'(MEM_LIMIT - {1'b0, raddr_ff});
               res0.clipped    = 1'b1;
               if (MEM_LIMIT > hend_ff) hend_in = MEM_LIMIT;
            end else begin
               res0.run_length = rlen_ff;
               if (rlen_ff != 16'd0 && run_end > hend_ff) hend_in = run_end;
            end
            phase_in = PH_ADDR;
            index_in = 3'd0;
            raddr_in = '0;
            if (rlen_ff != 16'd0) begin
               res_count = 2'd1;
               if (req_tlast) begin
                  res1.event_res   = EV_FIN;
                  res1.final_size  = image_size(base_clamp, hend_in);
                  res1.last_result = 1'b1;
                  res_count        = 2'd2;
                  start            = 1'b1;
               end
            end else if (req_tlast) begin
               res0             = '0;
               res0.event_res   = EV_FIN;
               res0.final_size  = image_size(base_clamp, hend_in);
               res0.last_result = 1'b1;
               res_count        = 2'd1;
               start            = 1'b1;
            end
         end
         default: begin
            if (req_tlast) start = 1'b1;
            else phase_in = PH_DONE;
         end
      endcase
      // a byte marked last restarts the parser at the header
      if (start) begin
         phase_in = PH_HEADER;
         index_in = 3'd0;
         raddr_in = '0;
         rlen_in  = '0;
         wptr_in  = '0;
         hend_in  = '0;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_write_enable) begin
         base_ff <= csr_write_data;
      end
   end

   // parser state update
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         index_ff <= '0;
         raddr_ff <= '0;
         rlen_ff  <= '0;
         wptr_ff  <= '0;
         hend_ff  <= '0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         raddr_ff <= raddr_in;
         rlen_ff  <= rlen_in;
         wptr_ff  <= wptr_in;
         hend_ff  <= hend_in;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (req_accept && res_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
         if (res_count == 2'd2) queue_ff[wr_ptr_ff + 2'd1] <= res1;
      end
   end

   // result queue pointers and fill count
   always_comb begin
      count_in = count_ff;
      if (req_accept) count_in = count_in + {1'b0, res_count};
      if (rsp_accept) count_in = count_in - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_accept) wr_ptr_ff <= wr_ptr_ff + res_count;
         if (rsp_accept) rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_in;
      end
   end

   // result port
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tuser  = queue_ff[rd_ptr_ff].event_res;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last_result;
   assign rsp_tdata  = {6'd0,
                        queue_ff[rd_ptr_ff].final_size,
                        queue_ff[rd_ptr_ff].clipped,
                        queue_ff[rd_ptr_ff].run_length,
                        queue_ff[rd_ptr_ff].write_value,
                        queue_ff[rd_ptr_ff].write_addr};

endmodule

@@ tb/ips_parser_checker.sv @@
// ips_parser_checker: watches the patch byte and result streams of the ips parser,
// predicts every result transaction and compares it field by field
// depends on ipsp_pkg for the result type, event codes, header bytes and eof marker
module ips_parser_checker #(
   parameter int MEM_BYTES = 16777216
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [24:0] csr_write_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          results_checked,
   output int          results_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ipsp_pkg::*;

   localparam logic [24:0] MEM_LIMIT = 25'(MEM_BYTES);

   typedef enum logic [2:0] {
      SCAN_HEADER,
      SCAN_ADDR,
      SCAN_LEN,
      SCAN_DATA,
      SCAN_RUN_COUNT,
      SCAN_RUN_FILL,
      SCAN_SKIP
   } scan_phase_type;

   // predictor copy of the parser state and base_size
   scan_phase_type phase;
   logic [2:0]  field_idx;
   logic [23:0] rec_addr;
   logic [15:0] rec_len;
   logic [24:0] wr_ptr;
   logic [24:0] high_end;
   logic [24:0] base_size;

   result_type expected_writes [$];

   function automatic result_type make_result(logic [2:0] ev, logic [23:0] addr,
                                              logic [7:0] val, logic [15:0] len,
                                              logic clip, logic [24:0] fsize,
                                              logic last);
      result_type r;
      r.event_res   = ev;
      r.write_addr  = addr;
      r.write_value = val;
      r.run_length  = len;
      r.clipped     = clip;
      r.final_size  = fsize;
      r.last_result = last;
      return r;
   endfunction

   task automatic restart_stream();
      phase     = SCAN_HEADER;
      field_idx = '0;
      rec_addr  = '0;
      rec_len   = '0;
      wr_ptr    = '0;
      high_end  = '0;
   endtask

   // a stream closed without its last byte skips input until one comes
   task automatic end_stream(input logic last);
      if (last) restart_stream();
      else phase = SCAN_SKIP;
   endtask

   // finish or truncation event carrying the patched image size
   task automatic report_end(input logic [2:0] ev, input logic last);
      logic [24:0] clamped;
      logic [24:0] size;
      clamped = (base_size > MEM_LIMIT) ? MEM_LIMIT : base_size;
      size = (clamped > high_end) ? clamped : high_end;
      expected_writes.push_back(make_result(ev, '0, '0, '0, 1'b0, size, 1'b1));
      end_stream(last);
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic last);
      logic [24:0] run_end;
      case (phase)
         SCAN_HEADER: begin
            if (b != MAGIC[field_idx] || last) begin
               expected_writes.push_back(make_result(EV_BADHDR, '0, '0, '0, 1'b0, '0, 1'b1));
               end_stream(last);
            end else if (field_idx == 3'd4) begin
               phase     = SCAN_ADDR;
               field_idx = '0;
               rec_addr  = '0;
            end else begin
               field_idx++;
            end
         end
         SCAN_ADDR: begin
            rec_addr = {rec_addr[15:0], b};
            if (field_idx < 3'd2) begin
               field_idx++;
               if (last) report_end(EV_TRUNC, 1'b1);
            end else begin
               field_idx = '0;
               if (rec_addr == EOF_MARK) report_end(EV_FIN, last);
               else if (last) report_end(EV_TRUNC, 1'b1);
               else begin
                  phase   = SCAN_LEN;
                  rec_len = '0;
               end
            end
         end
         SCAN_LEN: begin
            rec_len = {rec_len[7:0], b};
            if (field_idx == 3'd1) begin
               field_idx = '0;
               if (rec_len == '0) begin
                  phase = SCAN_RUN_COUNT;
               end else begin
                  phase  = SCAN_DATA;
                  wr_ptr = {1'b0, rec_addr};
               end
            end else begin
               field_idx++;
            end
            if (last) report_end(EV_TRUNC, 1'b1);
         end
         SCAN_DATA: begin
            // literal byte, clipped with zero length once the pointer leaves memory
            if (wr_ptr < MEM_LIMIT) begin
               expected_writes.push_back(make_result(EV_LIT, wr_ptr[23:0], b, 16'd1,
                                                     1'b0, '0, 1'b0));
               if (wr_ptr + 25'd1 > high_end) high_end = wr_ptr + 25'd1;
            end else begin
               expected_writes.push_back(make_result(EV_LIT, wr_ptr[23:0], b, 16'd0,
                                                     1'b1, '0, 1'b0));
            end
            if (wr_ptr < ADDR_SPACE) wr_ptr++;
            if (rec_len != '0) rec_len--;
            if (rec_len == '0) begin
               phase     = SCAN_ADDR;
               field_idx = '0;
               rec_addr  = '0;
               if (last) report_end(EV_FIN, 1'b1);
            end else if (last) begin
               report_end(EV_TRUNC, 1'b1);
            end
         end
         SCAN_RUN_COUNT: begin
            rec_len = {rec_len[7:0], b};
            if (field_idx == 3'd1) begin
               field_idx = '0;
               phase     = SCAN_RUN_FILL;
            end else begin
               field_idx++;
            end
            if (last) report_end(EV_TRUNC, 1'b1);
         end
         SCAN_RUN_FILL: begin
            // zero-count run emits nothing; a run crossing the memory end is cut
            if (rec_len != '0) begin
               run_end = {1'b0, rec_addr} + {9'b0, rec_len};
               if ({1'b0, rec_addr} >= MEM_LIMIT) begin
                  expected_writes.push_back(make_result(EV_RUN, rec_addr, b, 16'd0,
                                                        1'b1, '0, 1'b0));
               end else if (run_end > MEM_LIMIT) begin
                  expected_writes.push_back(make_result(EV_RUN, rec_addr, b,
                                                        16'(MEM_LIMIT - {1'b0, rec_addr}),
                                                        1'b1, '0, 1'b0));
                  if (MEM_LIMIT > high_end) high_end = MEM_LIMIT;
               end else begin
                  expected_writes.push_back(make_result(EV_RUN, rec_addr, b, rec_len,
                                                        1'b0, '0, 1'b0));
                  if (run_end > high_end) high_end = run_end;
               end
            end
            phase     = SCAN_ADDR;
            field_idx = '0;
            rec_addr  = '0;
            if (last) report_end(EV_FIN, 1'b1);
         end
         default: begin
            if (last) restart_stream();
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 40)
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // track config, predict on each accepted byte, compare each accepted result
   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      if (reset) begin
         expected_writes.delete();
         restart_stream();
         base_size       = '0;
         fail_count      = 0;
         results_checked = 0;
      end else begin
         if (csr_write_enable) base_size = csr_write_data;
         if (req_tvalid && req_tready) predict_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got.event_res   = rsp_tuser;
            got.write_addr  = rsp_tdata[23:0];
            got.write_value = rsp_tdata[31:24];
            got.run_length  = rsp_tdata[47:32];
            got.clipped     = rsp_tdata[48];
            got.final_size  = rsp_tdata[73:49];
            got.last_result = rsp_tlast;
            if (expected_writes.size() == 0) begin
               fail_count++;
               if (fail_count <= 40)
                  $display("%0t ns: unexpected result, expected none, actual event %0d addr %0h",
                           $time, got.event_res, got.write_addr);
            end else begin
               want = expected_writes.pop_front();
               check_field("event_res", 32'(want.event_res), 32'(got.event_res));
               check_field("write_addr", 32'(want.write_addr), 32'(got.write_addr));
               check_field("write_value", 32'(want.write_value), 32'(got.write_value));
               check_field("run_length", 32'(want.run_length), 32'(got.run_length));
               check_field("clipped", 32'(want.clipped), 32'(got.clipped));
               check_field("final_size", 32'(want.final_size), 32'(got.final_size));
               check_field("last_result", 32'(want.last_result), 32'(got.last_result));
               results_checked++;
            end
         end
      end
      results_pending <= expected_writes.size();
   end

endmodule

@@ tb/tb_ips_patch_stream_parser_unit.sv @@
// tb_ips_patch_stream_parser_unit: stimulus and verdict for the ips patch parser
// depends on ipsp_pkg, ips_patch_stream_parser_unit and ips_parser_checker
module tb_ips_patch_stream_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import ipsp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [24:0] csr_write_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int fail_count;
   int results_checked;
   int results_pending;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int bytes_sent = 0;
   int streams_sent = 0;

   logic [7:0] patch_bytes [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ips_patch_stream_parser_unit uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast)
   );

   ips_parser_checker stream_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast),
      .fail_count       (fail_count),
      .results_checked  (results_checked),
      .results_pending  (results_pending)
   );

   // result side back-pressure
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // one patch byte transaction, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_stream();
      foreach (patch_bytes[i]) send_byte(patch_bytes[i], i == patch_bytes.size() - 1);
      streams_sent++;
   endtask

   // hold off until every predicted result is out, plus pipeline slack
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_base(input logic [24:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      int          mix_bytes;
      int          n_records;
      int          ending;
      int          cut;
      int          k;
      logic [23:0] addr;
      logic [15:0] count;
      bit          paused;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_base(25'd0);

      // literal at the top address spilling past memory, then a full-count run
      patch_bytes = '{MAGIC[0], MAGIC[1], MAGIC[2], MAGIC[3], MAGIC[4],
                      8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h02, 8'h11, 8'h22,
                      8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
      send_stream();
      // header mismatch, then ignored bytes up to the last one
      patch_bytes = '{MAGIC[0], MAGIC[1], 8'h58, 8'h01};
      send_stream();

      for (int mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               write_base(25'($urandom_range(0, 16'hFFFF)));
            end
            1: begin
               send_idle_pct = 66;
               recv_stall_pct = 0;
               write_base(25'h1000000);
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 66;
               write_base(25'd0);
            end
            default: begin
               send_idle_pct = 25;
               recv_stall_pct = 25;
               write_base(25'($urandom_range(0, 25'h1000000)));
            end
         endcase
         mix_bytes = 0;
         paused = 1'b0;
         while (mix_bytes < 305) begin
            // header and a few records with random content
            patch_bytes.delete();
            for (int i = 0; i < 5; i++) patch_bytes.push_back(MAGIC[i]);
            n_records = $urandom_range(0, 4);
            repeat (n_records) begin
               case ($urandom_range(7))
                  0:       addr = 24'hFFFF00 | 24'($urandom_range(255));
                  1:       addr = 24'($urandom());
                  default: addr = 24'($urandom_range(16'hFFFF));
               endcase
               patch_bytes.push_back(addr[23:16]);
               patch_bytes.push_back(addr[15:8]);
               patch_bytes.push_back(addr[7:0]);
               if ($urandom_range(2) == 0) begin
                  case ($urandom_range(5))
                     0:       count = 16'h0000;
                     1:       count = 16'hFFFF;
                     2:       count = 16'($urandom());
                     default: count = 16'($urandom_range(1, 300));
                  endcase
                  patch_bytes.push_back(8'h00);
                  patch_bytes.push_back(8'h00);
                  patch_bytes.push_back(count[15:8]);
                  patch_bytes.push_back(count[7:0]);
                  patch_bytes.push_back(8'($urandom()));
               end else begin
                  count = 16'($urandom_range(1, 6));
                  patch_bytes.push_back(count[15:8]);
                  patch_bytes.push_back(count[7:0]);
                  repeat (count) patch_bytes.push_back(8'($urandom()));
               end
            end
            // how the stream ends: eof marker, record boundary, cut short, bad header
            ending = $urandom_range(9);
            if (ending <= 4) begin
               patch_bytes.push_back(EOF_MARK[23:16]);
               patch_bytes.push_back(EOF_MARK[15:8]);
               patch_bytes.push_back(EOF_MARK[7:0]);
               repeat ($urandom_range(0, 3)) patch_bytes.push_back(8'($urandom()));
            end else if (ending >= 7 && ending <= 8) begin
               cut = $urandom_range(0, patch_bytes.size() - 2);
               while (patch_bytes.size() > cut + 1) void'(patch_bytes.pop_back());
            end else if (ending == 9) begin
               k = $urandom_range(4);
               patch_bytes[k] = MAGIC[k] ^ 8'($urandom_range(1, 255));
            end
            send_stream();
            mix_bytes += patch_bytes.size();
            if (!paused && mix_bytes > 150) begin
               drain();
               paused = 1'b1;
            end
         end
      end

      drain();
      $display("covered %0d patch bytes in %0d streams over four flow-control mixes",
               bytes_sent, streams_sent);
      $display("compared %0d result transactions, base size from zero to full memory",
               results_checked);
      if (fail_count == 0)
         $display("ips_patch_stream_parser_unit test passed");
      else
         $display("ips_patch_stream_parser_unit test failed");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("ips_patch_stream_parser_unit test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
src/ipsp_pkg.sv
src/ips_patch_stream_parser_unit.sv
tb/ips_parser_checker.sv
tb/tb_ips_patch_stream_parser_unit.sv
